### rtl/pbwf_pkg.sv
// Shared types, codes and defaults for the protobuf wire field parser.
`default_nettype none
package pbwf_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 10;
    localparam int LENGTH_WIDTH_DEF     = 32;
    localparam int COUNT_W              = 4;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_VARINT    = 3'd0,
        EV_FIXED32   = 3'd1,
        EV_FIXED64   = 3'd2,
        EV_PAYLOAD   = 3'd3,
        EV_EMPTY     = 3'd4,
        EV_UNKNOWN   = 3'd5,
        EV_OVERLONG  = 3'd6,
        EV_TRUNCATED = 3'd7
    } event_t;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [28:0]        field_number;
        logic [2:0]         wire_kind;
        logic [63:0]        raw_value;
        logic signed [63:0] zigzag_value;
        logic [7:0]         payload_byte;
        logic               payload_last;
    } out_beat_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } result_t;

endpackage
`default_nettype wire

### rtl/pbwf_in_stage.sv
// Input register for incoming message byte beats.
`default_nettype none
module pbwf_in_stage
    import pbwf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_beat_t byte_beat,
    input  wire logic     take,
    output logic          held_valid,
    output in_beat_t      held_beat
);

    logic     valid_reg;
    in_beat_t beat_reg;

    // Hold the beat until the core takes it.
    assign byte_stall = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            beat_reg <= byte_beat;
        end
    end

endmodule
`default_nettype wire

### rtl/pbwf_core.sv
// Parse state and single-byte step logic of the wire field parser.
`default_nettype none
module pbwf_core
    import pbwf_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_WIDTH     = LENGTH_WIDTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire in_beat_t beat,
    output result_t       result
);

    phase_t                  phase_reg,  phase_next,  phase_step;
    logic [63:0]             acc_reg,    acc_next,    acc_step;
    logic [COUNT_W-1:0]      count_reg,  count_next,  count_step;
    logic [LENGTH_WIDTH-1:0] rem_reg,    rem_next,    rem_step;
    logic [28:0]             fnum_reg,   fnum_next,   fnum_step;
    logic [2:0]              wk_reg,     wk_next,     wk_step;

    logic [7:0]         b;
    logic [COUNT_W-1:0] count_inc;
    logic [6:0]         vshift;
    logic [5:0]         fshift;
    logic [63:0]        acc_var;
    logic [63:0]        acc_fix;
    logic               overlong;
    logic               fixed_done;
    logic               truncate;
    logic [31:0]        key;
    logic               len_zero;

    assign b         = beat.data_byte;
    assign count_inc = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign vshift    = {3'b000, count_reg} * 7'd7;
    assign fshift    = {count_reg[2:0], 3'b000};
    assign acc_var   = (count_reg < 4'd10) ? (acc_reg | ({57'd0, b[6:0]} << vshift[5:0]))
                                           : acc_reg;
    assign acc_fix   = acc_reg | ({56'd0, b} << fshift);
    assign overlong  = b[7] && (count_inc >= COUNT_W'(MAX_VARINT_BYTES));
    assign key       = acc_var[31:0];
    assign len_zero  = (acc_var[LENGTH_WIDTH-1:0] == '0);
    assign fixed_done = (wk_reg == WT_FIXED64) ? (count_inc == 4'd8) : (count_inc == 4'd4);

    // Advance the parse state by one byte, ignoring end of message.
    always_comb
    begin
        phase_step = phase_reg;
        acc_step   = acc_reg;
        count_step = count_reg;
        rem_step   = rem_reg;
        fnum_step  = fnum_reg;
        wk_step    = wk_reg;
        case (phase_reg)
            PH_KEY, PH_VALUE, PH_LENGTH:
            begin
                acc_step   = acc_var;
                count_step = count_inc;
                if (b[7])
                begin
                    if (overlong)
                    begin
                        phase_step = PH_KEY;
                        acc_step   = '0;
                        count_step = '0;
                    end
                end
                else
                begin
                    acc_step   = '0;
                    count_step = '0;
                    case (phase_reg)
                        PH_KEY:
                        begin
                            fnum_step = key[31:3];
                            wk_step   = key[2:0];
                            case (key[2:0])
                                WT_VARINT:  phase_step = PH_VALUE;
                                WT_FIXED64,
                                WT_FIXED32: phase_step = PH_FIXED;
                                WT_LENGTH:  phase_step = PH_LENGTH;
                                default:    phase_step = PH_KEY;
                            endcase
                        end
                        PH_VALUE:
                        begin
                            phase_step = PH_KEY;
                        end
                        default:
                        begin
                            rem_step   = acc_var[LENGTH_WIDTH-1:0];
                            phase_step = len_zero ? PH_KEY : PH_PAYLOAD;
                        end
                    endcase
                end
            end
            PH_FIXED:
            begin
                acc_step   = acc_fix;
                count_step = count_inc;
                if (fixed_done)
                begin
                    phase_step = PH_KEY;
                    acc_step   = '0;
                    count_step = '0;
                end
            end
            PH_PAYLOAD:
            begin
                if (rem_reg <= LENGTH_WIDTH'(1))
                begin
                    phase_step = PH_KEY;
                    rem_step   = '0;
                end
                else
                begin
                    rem_step = rem_reg - LENGTH_WIDTH'(1);
                end
            end
            default:
            begin
                phase_step = PH_KEY;
                acc_step   = '0;
                count_step = '0;
            end
        endcase
    end

    assign truncate = beat.end_of_message &&
                      ((phase_step != PH_KEY) || (count_step != '0));

    // Next state: drop any open field when the message ends inside it.
    always_comb
    begin
        phase_next = phase_step;
        acc_next   = acc_step;
        count_next = count_step;
        rem_next   = rem_step;
        fnum_next  = fnum_step;
        wk_next    = wk_step;
        if (truncate)
        begin
            phase_next = PH_KEY;
            acc_next   = '0;
            count_next = '0;
            rem_next   = '0;
        end
    end

    // Result of this byte, if any.
    always_comb
    begin
        result.valid             = 1'b0;
        result.beat.event_kind   = EV_VARINT;
        result.beat.field_number = fnum_reg;
        result.beat.wire_kind    = wk_reg;
        result.beat.raw_value    = '0;
        result.beat.zigzag_value = '0;
        result.beat.payload_byte = '0;
        result.beat.payload_last = 1'b0;
        case (phase_reg)
            PH_KEY, PH_VALUE, PH_LENGTH:
            begin
                if (b[7])
                begin
                    if (overlong)
                    begin
                        result.valid           = 1'b1;
                        result.beat.event_kind = EV_OVERLONG;
                        if (phase_reg == PH_KEY)
                        begin
                            result.beat.field_number = '0;
                            result.beat.wire_kind    = '0;
                        end
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_KEY:
                        begin
                            result.beat.field_number = key[31:3];
                            result.beat.wire_kind    = key[2:0];
                            result.beat.event_kind   = EV_UNKNOWN;
                            result.valid = !((key[2:0] == WT_VARINT) ||
                                             (key[2:0] == WT_FIXED64) ||
                                             (key[2:0] == WT_FIXED32) ||
                                             (key[2:0] == WT_LENGTH));
                        end
                        PH_VALUE:
                        begin
                            result.valid             = 1'b1;
                            result.beat.event_kind   = EV_VARINT;
                            result.beat.raw_value    = acc_var;
                            result.beat.zigzag_value = (acc_var >> 1) ^ {64{acc_var[0]}};
                        end
                        default:
                        begin
                            result.valid           = len_zero;
                            result.beat.event_kind = EV_EMPTY;
                        end
                    endcase
                end
            end
            PH_FIXED:
            begin
                result.valid           = fixed_done;
                result.beat.event_kind = (wk_reg == WT_FIXED64) ? EV_FIXED64 : EV_FIXED32;
                result.beat.raw_value  = acc_fix;
            end
            PH_PAYLOAD:
            begin
                result.valid             = 1'b1;
                result.beat.event_kind   = EV_PAYLOAD;
                result.beat.payload_byte = b;
                result.beat.payload_last = (rem_reg <= LENGTH_WIDTH'(1));
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
        if (truncate)
        begin
            result.valid             = 1'b1;
            result.beat.event_kind   = EV_TRUNCATED;
            result.beat.field_number = (phase_step == PH_KEY) ? 29'd0 : fnum_step;
            result.beat.wire_kind    = (phase_step == PH_KEY) ? 3'd0 : wk_step;
            result.beat.raw_value    = '0;
            result.beat.zigzag_value = '0;
            result.beat.payload_byte = '0;
            result.beat.payload_last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            acc_reg   <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
            fnum_reg  <= '0;
            wk_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            fnum_reg  <= fnum_next;
            wk_reg    <= wk_next;
        end
    end

endmodule
`default_nettype wire

### rtl/pbwf_out_stage.sv
// Result register for outgoing field event beats.
`default_nettype none
module pbwf_out_stage
    import pbwf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         free,
    output logic         event_valid,
    input  wire logic    event_stall,
    output out_beat_t    event_beat
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign free        = !valid_reg || !event_stall;
    assign event_valid = valid_reg;
    assign event_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load && result.valid)
        begin
            beat_reg <= result.beat;
        end
    end

endmodule
`default_nettype wire

### rtl/protobuf_wire_field_parser.sv
// Top level of the protobuf wire-format field parser.
//
//   channel | direction | beat type  | handshake
//   --------+-----------+------------+------------------------------
//   byte    | in        | in_beat_t  | byte_valid / byte_stall
//   event   | out       | out_beat_t | event_valid / event_stall
//
// One message byte per cycle while nothing stalls: a byte beat is registered,
// stepped through the parse state combinationally and its event, if any,
// lands in the result register at the next edge, so an event is offered in
// the cycle after its byte is taken. Rate is set by the combinational parse
// step; bytes that make no event (key bytes, leading varint bytes, early fixed
// bytes) leave the output idle. Reset clears the parse state to
// "expecting key" and both stage valids. A stall on the event side holds the
// result register, then the input register, and then raises byte_stall.
`default_nettype none
module protobuf_wire_field_parser
    import pbwf_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF,
    parameter int LENGTH_WIDTH     = LENGTH_WIDTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_beat_t byte_beat,
    output logic          event_valid,
    input  wire logic     event_stall,
    output out_beat_t     event_beat
);

    logic     held_valid;
    in_beat_t held_beat;
    logic     out_free;
    logic     advance;
    result_t  result;

    // Step the parser only when the result register can take its event.
    assign advance = held_valid && out_free;

    pbwf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .take       (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    pbwf_core #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .LENGTH_WIDTH     (LENGTH_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .beat    (held_beat),
        .result  (result)
    );

    pbwf_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .result      (result),
        .free        (out_free),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_beat  (event_beat)
    );

endmodule
`default_nettype wire
